// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PN_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define PN_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define PN_ASSERT(lbl, clk, rstn, prop)
`define PN_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- sv/pnorm_pkg.sv -----
// types and constants of the path normalizer
// no dependencies
package pnorm_pkg;

	localparam logic [7:0] SEP_CHAR = 8'h2F;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam logic KIND_READ = 1'b1;

	localparam int NODE_W = 11;
	localparam int CFG_W  = 11;

	localparam logic [9:0]  MAX_NODE_RST = 10'd256;
	localparam logic [10:0] LIMIT_RST    = 11'd1000;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NODE_LONG = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_ABOVE_TOP = 2'd3
	} status_t;

	typedef enum logic {
		REG_MAX_NODE     = 1'b0,
		REG_LENGTH_LIMIT = 1'b1
	} cfg_reg_t;

endpackage

// ----- sv/path_normalizer_unit.sv -----
// path normalizer top level: stream in, stream out, config write port
// depends on pnorm_pkg, pnorm_ram and assert_macros.svh
//
// usage
// - s_* carries one item per transfer: a path byte (tuser 0) with tlast on the
//   final byte of a path, or a read of the normalized path (tuser 1)
// - m_* returns one result per item: status, path length, read byte; tlast is
//   set on the result of a path's final byte
// - items are accepted back to back while s_tready is high
// - a result goes through a stage register, loaded at the transfer, and then
//   the output register, from which it is on m_*; the read byte comes from the
//   path memory's registered port
// - node start offsets live in a stack memory, its top entry is held in a
//   register and refilled by a memory read the cycle after a pop
// - the path memory has one write port; a slash written by the last byte of a
//   path may go to the memory late and reads of it are forwarded
// - when m_tready is low two results are held, then s_tready drops
// - reset restores the register defaults and empties the stack and path; the
//   memories are not cleared, no start-up sweep is needed
// - cfg writes take effect at once; users make them only while idle, not enforced
module path_normalizer_unit #(
	parameter int PATH_BYTES  = 1024,
	parameter int STACK_DEPTH = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,  // char_byte[7:0], read_index[17:8], zeros
	input  logic                s_tuser,  // kind
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,  // status[1:0], path_length[12:2], read_byte[20:13]
	output logic                m_tlast,
	input  logic                cfg_we,
	input  pnorm_pkg::cfg_reg_t cfg_index,
	input  logic [10:0]         cfg_data
);

	import pnorm_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = $clog2(PATH_BYTES);
	localparam int LW = $clog2(PATH_BYTES + 1);
	localparam int IW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = ((LW > NODE_W) ? LW : NODE_W) + 2;
	localparam int XW = (LW > 10) ? LW : 10;

	logic [9:0]        max_q;
	logic [CFG_W-1:0]  limit_q;

	logic [LW-1:0]     plen_q;
	logic [CW-1:0]     cnt_q;
	logic [NODE_W-1:0] nc_q;
	logic [15:0]       head_q;
	logic              root_q;
	logic              start_q;
	status_t           err_q;
	logic [LW-1:0]     tos_q;
	logic              fill_q;
	logic              pend_v_q;
	logic [AW-1:0]     pend_addr_q;

	logic              valid_s1;
	logic              read_s1;
	logic              inrange_s1;
	logic              fwd_s1;
	status_t           status_s1;
	logic              done_s1;
	logic [LW-1:0]     len_s1;

	logic              res_valid_q;
	status_t           res_status_q;
	logic              res_done_q;
	logic [10:0]       res_len_q;
	logic [7:0]        res_byte_q;

	logic [7:0]        char_in;
	logic [9:0]        idx_in;
	logic [XW-1:0]     idx_x;
	logic              adv_out;
	logic              accept;
	logic              accept_w;
	logic              accept_r;

	logic [LW-1:0]     ol;
	logic [CW-1:0]     cnt;
	logic [CW-1:0]     cnt_m1;
	logic [NODE_W-1:0] nc;
	logic [NODE_W-1:0] lim1;
	logic [NODE_W-1:0] fin_n;
	logic [15:0]       head;
	logic              root;
	status_t           err;
	logic              start_d;
	logic              done;
	logic              sep;
	logic              slash;
	logic              fin;
	logic              byte_we;
	logic [AW-1:0]     byte_addr;
	logic [7:0]        byte_data;
	logic              slash_we;
	logic [AW-1:0]     slash_addr;
	logic              push;
	logic              pop;
	logic [IW-1:0]     push_addr;
	logic [LW-1:0]     push_val;
	logic [SW-1:0]     pos;
	logic [SW-1:0]     new_len;

	logic              ps_we;
	logic [AW-1:0]     ps_waddr;
	logic [7:0]        ps_wdata;
	logic [7:0]        ps_rdata;
	logic [LW-1:0]     stk_rdata;
	logic              pend_set;
	logic              pend_keep;
	logic [7:0]        rb;

	assign char_in  = s_tdata[7:0];
	assign idx_in   = s_tdata[17:8];
	assign idx_x    = XW'(idx_in);
	assign adv_out  = !res_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_out;
	assign accept   = s_tvalid && s_tready;
	assign accept_w = accept && (s_tuser != KIND_READ);
	assign accept_r = accept && (s_tuser == KIND_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_NODE_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_NODE:     max_q   <= cfg_data[9:0];
				REG_LENGTH_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-item state update for path bytes
	always_comb begin
		ol         = start_q ? '0 : plen_q;
		cnt        = start_q ? '0 : cnt_q;
		nc         = start_q ? '0 : nc_q;
		head       = start_q ? '0 : head_q;
		root       = start_q ? 1'b0 : root_q;
		err        = start_q ? ST_OK : err_q;
		start_d    = 1'b0;
		done       = 1'b0;
		sep        = (char_in == SEP_CHAR);
		lim1       = NODE_W'(max_q) + NODE_W'(1);
		fin        = 1'b0;
		fin_n      = '0;
		byte_we    = 1'b0;
		byte_addr  = '0;
		byte_data  = char_in;
		slash_we   = 1'b0;
		slash_addr = '0;
		push       = 1'b0;
		pop        = 1'b0;
		push_addr  = '0;
		push_val   = ol;
		pos        = '0;
		new_len    = '0;
		cnt_m1     = '0;
		slash      = 1'b0;

		if (start_q && sep) begin
			root      = 1'b1;
			ol        = LW'(1);
			byte_we   = 1'b1;
			byte_addr = '0;
			byte_data = SEP_CHAR;
		end else if (err == ST_OK) begin
			slash = (ol > LW'(root));
			if (sep) begin
				fin   = 1'b1;
				fin_n = nc;
				nc    = '0;
			end else if (nc >= lim1) begin
				err = ST_NODE_LONG;
				nc  = '0;
			end else begin
				if (nc == NODE_W'(0)) begin
					head[7:0] = char_in;
				end else if (nc == NODE_W'(1)) begin
					head[15:8] = char_in;
				end
				pos = SW'(ol) + SW'(slash) + SW'(nc);
				if (pos < SW'(PATH_BYTES)) begin
					byte_we   = 1'b1;
					byte_addr = pos[AW-1:0];
				end
				nc = nc + NODE_W'(1);
				if (s_tlast) begin
					fin   = 1'b1;
					fin_n = nc;
				end
			end
		end

		if (fin && fin_n != '0) begin
			if (fin_n == NODE_W'(1) && head[7:0] == DOT_CHAR) begin
				pop = 1'b0;
			end else if (fin_n == NODE_W'(2) && head == {DOT_CHAR, DOT_CHAR}) begin
				if (cnt == '0) begin
					if (!root) begin
						err = ST_ABOVE_TOP;
					end
				end else begin
					pop = 1'b1;
					cnt = cnt - CW'(1);
					ol  = tos_q;
				end
			end else begin
				new_len = SW'(ol) + SW'(slash) + SW'(fin_n);
				if (new_len > SW'(limit_q) || new_len > SW'(PATH_BYTES)
						|| cnt >= CW'(STACK_DEPTH)) begin
					err = ST_OVERFLOW;
				end else begin
					push       = 1'b1;
					push_addr  = cnt[IW-1:0];
					push_val   = ol;
					slash_we   = slash;
					slash_addr = ol[AW-1:0];
					cnt        = cnt + CW'(1);
					ol         = new_len[LW-1:0];
				end
			end
		end
		cnt_m1 = cnt - CW'(1);

		if (s_tlast) begin
			nc      = '0;
			start_d = 1'b1;
			done    = 1'b1;
		end
	end

	// path memory write port: node byte, then slash, then a deferred slash
	always_comb begin
		ps_we    = 1'b0;
		ps_waddr = pend_addr_q;
		ps_wdata = SEP_CHAR;
		if (accept_w && byte_we) begin
			ps_we    = 1'b1;
			ps_waddr = byte_addr;
			ps_wdata = byte_data;
		end else if (accept_w && slash_we) begin
			ps_we    = 1'b1;
			ps_waddr = slash_addr;
		end else if (pend_v_q) begin
			ps_we = 1'b1;
		end
	end

	assign pend_set  = accept_w && byte_we && slash_we;
	assign pend_keep = pend_v_q && accept_w && (byte_we || slash_we) && !start_q;

	pnorm_ram #(
		.WIDTH(8),
		.DEPTH(PATH_BYTES)
	) u_path_ram (
		.clk  (clk),
		.we   (ps_we),
		.waddr(ps_waddr),
		.wdata(ps_wdata),
		.re   (accept_r),
		.raddr(idx_x[AW-1:0]),
		.rdata(ps_rdata)
	);

	pnorm_ram #(
		.WIDTH(LW),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (accept_w && push),
		.waddr(push_addr),
		.wdata(push_val),
		.re   (accept_w && pop),
		.raddr(cnt_m1[IW-1:0]),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= '0;
			cnt_q    <= '0;
			nc_q     <= '0;
			head_q   <= '0;
			root_q   <= 1'b0;
			start_q  <= 1'b1;
			err_q    <= ST_OK;
			fill_q   <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			fill_q   <= accept_w && pop;
			pend_v_q <= pend_set || pend_keep;
			if (accept_w) begin
				plen_q  <= ol;
				cnt_q   <= cnt;
				nc_q    <= nc;
				head_q  <= head;
				root_q  <= root;
				start_q <= start_d;
				err_q   <= err;
			end
		end
	end

	// top of stack: a push wins over a pending refill
	always_ff @(posedge clk) begin
		if (accept_w && push) begin
			tos_q <= push_val;
		end else if (fill_q) begin
			tos_q <= stk_rdata;
		end
		if (pend_set) begin
			pend_addr_q <= slash_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_out) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1    <= accept_r;
			inrange_s1 <= XW'(idx_in) < XW'(plen_q);
			fwd_s1     <= pend_v_q && (pend_addr_q == idx_x[AW-1:0]);
			status_s1  <= accept_r ? err_q : err;
			done_s1    <= accept_r ? 1'b0 : done;
			len_s1     <= accept_r ? plen_q : ol;
		end
		if (adv_out && valid_s1) begin
			res_status_q <= status_s1;
			res_done_q   <= done_s1;
			res_len_q    <= 11'(len_s1);
			res_byte_q   <= rb;
		end
	end

	assign rb = (read_s1 && inrange_s1) ? (fwd_s1 ? SEP_CHAR : ps_rdata) : 8'h00;

	assign m_tvalid = res_valid_q;
	assign m_tlast  = res_done_q;
	assign m_tdata  = {3'b000, res_byte_q, res_len_q, res_status_q};

	`PN_ASSERT(a_stack_bound, clk, arst_n, cnt_q <= CW'(STACK_DEPTH))
	`PN_ASSERT(a_pend_single, clk, arst_n, pend_v_q |=> !pend_v_q)
	`PN_ASSERT(a_fill_no_pop, clk, arst_n, fill_q |-> !(accept_w && pop))
	`PN_ASSERT_NEVER(a_len_bound, clk, arst_n, plen_q > LW'(PATH_BYTES))

endmodule

// ----- sv/pnorm_ram.sv -----
// generic single write port ram with registered read and read enable
// no dependencies
module pnorm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench of path_normalizer_unit: path bytes and reads go in as transfers,
// every result is compared with a behavioral predictor of the normalizer kept in this file
// depends on pnorm_pkg and the rtl of path_normalizer_unit
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pnorm_pkg::*;

	localparam int PATH_BYTES     = 1024;
	localparam int STACK_DEPTH    = 512;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic KIND_BYTE    = 1'b0;

	typedef struct packed {
		status_t    status;
		logic       done;
		logic [10:0] len;
		logic [7:0] rbyte;
	} norm_result_t;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	cfg_reg_t    cfg_index = REG_MAX_NODE;
	logic [10:0] cfg_data = '0;

	path_normalizer_unit #(
		.PATH_BYTES(PATH_BYTES),
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0] norm_path [PATH_BYTES];
	int         node_starts [STACK_DEPTH];
	int         kept_nodes = 0;
	int         norm_len = 0;
	int         node_len = 0;
	logic [15:0] node_prefix = '0;
	logic       is_rooted = 1'b0;
	logic       path_fresh = 1'b1;
	status_t    path_status = ST_OK;
	int         cur_max_node = 256;
	int         cur_len_limit = 1000;

	norm_result_t pending_results[$];
	bit  idle_on = 1'b1;
	int  fail_count = 0;
	int  results_checked = 0;
	int  bytes_sent = 0;
	int  reads_sent = 0;
	int  settings_used = 1;
	int  status_seen [4];
	int  stall_left = 0;
	int  quiet_cycles = 0;

	initial begin
		foreach (norm_path[i]) norm_path[i] = '0;
		foreach (status_seen[i]) status_seen[i] = 0;
	end

	function automatic int slash_gap();
		return (norm_len > (is_rooted ? 1 : 0)) ? 1 : 0;
	endfunction

	function automatic void close_node();
		int n;
		int s;
		int new_len;
		n = node_len;
		node_len = 0;
		if (n == 0 || path_status != ST_OK) return;
		if (n == 1 && node_prefix[7:0] == DOT_CHAR) return;
		if (n == 2 && node_prefix == {DOT_CHAR, DOT_CHAR}) begin
			if (kept_nodes == 0) begin
				if (!is_rooted) path_status = ST_ABOVE_TOP;
				return;
			end
			kept_nodes--;
			norm_len = node_starts[kept_nodes];
			return;
		end
		s = slash_gap();
		new_len = norm_len + s + n;
		if (new_len > cur_len_limit || new_len > PATH_BYTES
				|| kept_nodes >= STACK_DEPTH) begin
			path_status = ST_OVERFLOW;
			return;
		end
		node_starts[kept_nodes] = norm_len;
		kept_nodes++;
		if (s != 0) norm_path[norm_len] = SEP_CHAR;
		norm_len = new_len;
	endfunction

	function automatic void absorb_char(logic [7:0] ch);
		int pos;
		if (path_fresh) begin
			path_fresh = 1'b0;
			norm_len = 0;
			kept_nodes = 0;
			node_len = 0;
			node_prefix = '0;
			is_rooted = 1'b0;
			path_status = ST_OK;
			if (ch == SEP_CHAR) begin
				is_rooted = 1'b1;
				norm_path[0] = SEP_CHAR;
				norm_len = 1;
				return;
			end
		end
		if (path_status != ST_OK) return;
		if (ch == SEP_CHAR) begin
			close_node();
			return;
		end
		if (node_len >= cur_max_node + 1) begin
			path_status = ST_NODE_LONG;
			node_len = 0;
			return;
		end
		if (node_len == 0) node_prefix = {8'h00, ch};
		else if (node_len == 1) node_prefix[15:8] = ch;
		pos = norm_len + slash_gap() + node_len;
		if (pos < PATH_BYTES) norm_path[pos] = ch;
		node_len++;
	endfunction

	function automatic norm_result_t predict_item(logic kind, logic [7:0] ch, logic fin,
			logic [9:0] idx);
		norm_result_t r;
		r.rbyte = '0;
		r.done = 1'b0;
		if (kind == KIND_READ) begin
			if (int'(idx) < norm_len) r.rbyte = norm_path[idx];
		end else begin
			absorb_char(ch);
			if (fin) begin
				if (path_status == ST_OK) close_node();
				node_len = 0;
				path_fresh = 1'b1;
				r.done = 1'b1;
				status_seen[path_status]++;
			end
		end
		r.status = path_status;
		r.len = 11'(norm_len);
		return r;
	endfunction

	function automatic void note_mismatch(string what, norm_result_t want, norm_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display({"mismatch (%s): expected status %0d done %0b len %0d byte %02h,",
				" got status %0d done %0b len %0d byte %02h"},
				what, want.status, want.done, want.len, want.rbyte,
				got.status, got.done, got.len, got.rbyte);
	endfunction

	// result checker
	always @(posedge clk) begin
		norm_result_t got;
		norm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = status_t'(m_tdata[1:0]);
			got.done = m_tlast;
			got.len = m_tdata[12:2];
			got.rbyte = m_tdata[20:13];
			if (pending_results.size() == 0) begin
				note_mismatch("result with nothing pending", got, got);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got !== want) note_mismatch("result fields", want, got);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] ch, input logic fin,
			input logic [9:0] idx);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tlast <= fin;
		s_tdata <= {6'd0, idx, ch};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_item(kind, ch, fin, idx));
		if (kind == KIND_READ) reads_sent++;
		else bytes_sent++;
	endtask

	task automatic send_read(input logic [9:0] idx);
		send_item(KIND_READ, 8'($urandom), 1'($urandom), idx);
	endtask

	task automatic send_read_random();
		if (norm_len > 0 && $urandom_range(0, 3) != 0)
			send_read(10'($urandom_range(0, norm_len - 1)));
		else
			send_read(10'($urandom_range(0, 1023)));
	endtask

	task automatic send_bytes(input byte_q_t text, input bit mid_reads);
		foreach (text[i]) begin
			if (mid_reads && $urandom_range(0, 15) == 0) send_read_random();
			send_item(KIND_BYTE, text[i], i == text.size() - 1, 10'($urandom_range(0, 1023)));
		end
	endtask

	task automatic send_text(input string s);
		byte_q_t text;
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
		send_bytes(text, 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [9:0] node_max, input logic [10:0] limit);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_NODE;
		cfg_data <= {1'b0, node_max};
		@(posedge clk);
		cur_max_node = node_max;
		cfg_index <= REG_LENGTH_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cur_len_limit = limit;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] plain_char();
		logic [7:0] ch;
		do ch = 8'($urandom_range(0, 255)); while (ch == SEP_CHAR);
		return ch;
	endfunction

	// well-formed path: optional root, nodes of names, dots, dot-dots and empties
	function automatic byte_q_t make_path();
		byte_q_t q;
		int nodes;
		int name_len;
		int cap;
		if ($urandom_range(0, 1)) q.push_back(SEP_CHAR);
		nodes = $urandom_range(1, 6);
		cap = (cur_max_node + 3 < 40) ? cur_max_node + 3 : 40;
		for (int i = 0; i < nodes; i++) begin
			if (i > 0) q.push_back(SEP_CHAR);
			case ($urandom_range(0, 9))
				0: q.push_back(DOT_CHAR);
				1, 2: begin
					q.push_back(DOT_CHAR);
					q.push_back(DOT_CHAR);
				end
				3: ;
				default: begin
					name_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cap)
						: $urandom_range(1, 3);
					repeat (name_len)
						q.push_back(($urandom_range(0, 7) == 0) ? DOT_CHAR : plain_char());
				end
			endcase
		end
		if ($urandom_range(0, 4) == 0) q.push_back(SEP_CHAR);
		if (q.size() == 0) q.push_back(plain_char());
		return q;
	endfunction

	function automatic byte_q_t make_noise();
		byte_q_t q;
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 7))
				0, 1, 2: q.push_back(SEP_CHAR);
				3, 4: q.push_back(DOT_CHAR);
				default: q.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		return q;
	endfunction

	task automatic random_unit();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) send_bytes(make_path(), 1'b1);
		else if (pick == 7) send_bytes(make_noise(), 1'b0);
		else repeat ($urandom_range(1, 3)) send_read_random();
	endtask

	task automatic test_directed_cases();
		send_text("/");
		send_text("/../a");
		send_text("x//./y/");
		send_read(10'd0);
		send_read(10'd2);
		send_read(10'd3);
		send_read(10'd1023);
		send_text("../b");
		send_item(KIND_BYTE, 8'h00, 1'b0, 10'd0);
		send_item(KIND_BYTE, 8'hFF, 1'b1, 10'd1023);
		send_read(10'd1);
	endtask

	task automatic test_tight_limits();
		set_config(10'd1, 11'd1);
		send_text("/");
		send_text("/a");
		send_text("abc");
		send_text("a");
		send_read(10'd0);
		send_text("a/b");
	endtask

	// root plus one node filling the length limit, then a node that overflows
	task automatic test_long_path();
		byte_q_t text;
		set_config(10'd1023, 11'd120);
		text.push_back(SEP_CHAR);
		repeat (119) text.push_back(plain_char());
		text.push_back(SEP_CHAR);
		text.push_back(8'h62);
		send_bytes(text, 1'b0);
		send_read(10'd0);
		send_read(10'd119);
		send_read(10'd120);
		send_read(10'd1023);
		repeat (20) send_read_random();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		for (int ph = 0; ph < 6; ph++) begin
			idle_on = (ph != 2);
			case (ph)
				0: set_config(10'd2, 11'd6);
				1: set_config(10'd3, 11'd12);
				2: set_config(10'd1023, 11'd1024);
				3: set_config(10'd1, 11'd1);
				4: set_config(10'($urandom_range(1, 6)), 11'($urandom_range(3, 40)));
				default: set_config(10'($urandom_range(1, 1023)),
					11'($urandom_range(1, 1024)));
			endcase
			stop_at = bytes_sent + reads_sent + 30;
			while (bytes_sent + reads_sent < stop_at) random_unit();
		end
	endtask

	task automatic test_quiet_finish();
		int stop_at;
		idle_on = 1'b0;
		set_config(10'd256, 11'd1000);
		while (stall_left > 0) @(posedge clk);
		stop_at = bytes_sent + reads_sent + 40;
		while (bytes_sent + reads_sent < stop_at) random_unit();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_tight_limits();
		test_long_path();
		test_random_traffic();
		test_quiet_finish();
		wait_drained();
		repeat (6) @(posedge clk);
		$display("%0d path bytes and %0d reads over %0d register settings,",
			bytes_sent, reads_sent, settings_used);
		$display("%0d results checked; finished paths: ok %0d, node too long %0d,",
			results_checked, status_seen[ST_OK], status_seen[ST_NODE_LONG]);
		$display("overflow %0d, above top %0d",
			status_seen[ST_OVERFLOW], status_seen[ST_ABOVE_TOP]);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
